[src/mket_pkg.sv]
// Package of the multi-key event tracker: request and result payload types,
// configuration types, operation codes and register indexes.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mket_pkg;

    // Operation codes of an input request.
    localparam logic [2:0] OP_SCAN         = 3'd0;
    localparam logic [2:0] OP_IS_PRESSED   = 3'd1;
    localparam logic [2:0] OP_IS_RELEASED  = 3'd2;
    localparam logic [2:0] OP_HELD_BEYOND  = 3'd3;
    localparam logic [2:0] OP_READ_HOLD    = 3'd4;

    // Register indexes, taken from paddr[2].
    localparam logic REG_RELEASE_MASK = 1'b0;
    localparam logic REG_DOWN_LEVEL   = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] first_levels;
        logic [15:0] confirm_levels;
        logic [31:0] now_ticks;
        logic [3:0]  key_index;
        logic [31:0] hold_threshold;
    } mket_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hold_ticks;
        logic [15:0] stable_levels;
    } mket_out_t;

    typedef struct packed {
        logic [15:0] release_event_mask;
        logic        down_level;
    } mket_cfg_t;

endpackage

`default_nettype wire

[src/mket_keys.sv]
// Key state of the multi-key event tracker: debounced levels, press ticks,
// holding times and event flags, with the scan and query logic of one request.
// Depends on mket_pkg.
`default_nettype none

module mket_keys #(
    parameter int NUM_KEYS   = 16,
    parameter int TICK_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   fire,
    input  mket_pkg::mket_in_t    item,
    input  mket_pkg::mket_cfg_t   cfg,
    output mket_pkg::mket_out_t   result
);
    import mket_pkg::*;

    logic [NUM_KEYS-1:0]   stable_reg, stable_next;
    logic [NUM_KEYS-1:0]   pressed_reg, pressed_next;
    logic [NUM_KEYS-1:0]   released_reg, released_next;
    logic [TICK_WIDTH-1:0] press_tick_reg [NUM_KEYS];
    logic [TICK_WIDTH-1:0] press_tick_next [NUM_KEYS];
    logic [TICK_WIDTH-1:0] held_reg [NUM_KEYS];
    logic [TICK_WIDTH-1:0] held_next [NUM_KEYS];

    logic [NUM_KEYS+15:0]  first_ext, confirm_ext, mask_ext, stable_ext;
    logic [TICK_WIDTH+31:0] now_ext;
    logic [TICK_WIDTH-1:0] now_t;
    logic [5:0]            key_w;
    logic                  key_ok;
    logic                  sel_stable, sel_pressed, sel_released, sel_down;
    logic [NUM_KEYS-1:0]   sel_mask;
    logic [TICK_WIDTH-1:0] sel_held;
    logic [TICK_WIDTH+31:0] held_w, thr_w;
    logic                  lv, changed, down;
    logic                  hit;
    logic [31:0]           hold;

    // Keys above the sixteen input pins see level zero and no release enable.
    assign first_ext   = {{NUM_KEYS{1'b0}}, item.first_levels};
    assign confirm_ext = {{NUM_KEYS{1'b0}}, item.confirm_levels};
    assign mask_ext    = {{NUM_KEYS{1'b0}}, cfg.release_event_mask};
    assign now_ext     = {{TICK_WIDTH{1'b0}}, item.now_ticks};
    assign now_t       = now_ext[TICK_WIDTH-1:0];
    assign key_w       = {2'b00, item.key_index};
    assign key_ok      = key_w < 6'(NUM_KEYS);

    // Query key selection.
    always_comb begin
        sel_stable   = 1'b0;
        sel_pressed  = 1'b0;
        sel_released = 1'b0;
        sel_held     = '0;
        sel_mask     = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (key_w == 6'(k)) begin
                sel_stable   = stable_reg[k];
                sel_pressed  = pressed_reg[k];
                sel_released = released_reg[k];
                sel_held     = held_reg[k];
                sel_mask[k]  = 1'b1;
            end
        end
    end

    assign sel_down = sel_stable == cfg.down_level;
    assign held_w   = {32'd0, sel_held};
    assign thr_w    = {{TICK_WIDTH{1'b0}}, item.hold_threshold};

    always_comb begin
        stable_next     = stable_reg;
        pressed_next    = pressed_reg;
        released_next   = released_reg;
        press_tick_next = press_tick_reg;
        held_next       = held_reg;
        hit             = 1'b0;
        hold            = 32'd0;
        lv              = 1'b0;
        changed         = 1'b0;
        down            = 1'b0;
        if (item.op == OP_SCAN) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                // A first sample that disagrees is replaced by the confirm sample.
                lv      = (first_ext[k] != stable_reg[k]) ? confirm_ext[k] : first_ext[k];
                changed = lv != stable_reg[k];
                down    = lv == cfg.down_level;
                if (changed && down) begin
                    press_tick_next[k] = now_t;
                    pressed_next[k]    = 1'b1;
                    released_next[k]   = 1'b0;
                end else if (changed) begin
                    pressed_next[k] = 1'b0;
                    if (mask_ext[k]) begin
                        released_next[k] = 1'b1;
                    end
                end else if (down) begin
                    held_next[k] = now_t - press_tick_reg[k];
                end else begin
                    press_tick_next[k] = '0;
                    held_next[k]       = '0;
                end
                stable_next[k] = lv;
            end
        end else if (key_ok) begin
            case (item.op)
                OP_IS_PRESSED: begin
                    if (sel_down && sel_pressed) begin
                        hit          = 1'b1;
                        pressed_next = pressed_reg & ~sel_mask;
                    end
                end
                OP_IS_RELEASED: begin
                    if (!sel_down && sel_released) begin
                        hit           = 1'b1;
                        released_next = released_reg & ~sel_mask;
                    end
                end
                OP_HELD_BEYOND: begin
                    if (sel_down && sel_pressed && (held_w > thr_w)) begin
                        hit          = 1'b1;
                        pressed_next = pressed_reg & ~sel_mask;
                    end
                end
                OP_READ_HOLD: begin
                    if (sel_down) begin
                        hit  = 1'b1;
                        hold = held_w[31:0];
                    end
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Levels of keys that do not exist read as one.
    assign stable_ext           = {16'hFFFF, stable_next};
    assign result.hit           = hit;
    assign result.hold_ticks    = hold;
    assign result.stable_levels = stable_ext[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg   <= '1;
            pressed_reg  <= '0;
            released_reg <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_tick_reg[k] <= '0;
                held_reg[k]       <= '0;
            end
        end else if (fire) begin
            stable_reg     <= stable_next;
            pressed_reg    <= pressed_next;
            released_reg   <= released_next;
            press_tick_reg <= press_tick_next;
            held_reg       <= held_next;
        end
    end

endmodule

`default_nettype wire

[src/multi_key_event_tracker.sv]
// Multi-key event tracker: debounces up to NUM_KEYS keys and reports press,
// release and holding-time events.
// Usage:
//   Requests enter on s_valid/s_ready/s_item; each request yields exactly one
//   result on m_valid/m_ready/m_result, in order. A scan request carries two
//   pin samples and the current tick; query requests ask about one key, and
//   the press and release queries clear the event flag they consume.
//   A request is captured in an input register and processed from there; the
//   edge that fires it loads the result register and raises m_valid. While the
//   receiver takes results, one request is taken every cycle; the scan
//   updates all keys side by side, whatever NUM_KEYS is.
//   When the receiver stalls, the result register holds its item and the input
//   register keeps one more request; s_ready drops once both are full.
//   Reset (aresetn low, synchronous) empties both registers, sets every key
//   up (all levels one), clears flags, ticks and configuration.
//   Configuration goes through the APB port: release_event_mask at 0x0,
//   down_level at 0x4; write it only while no request is in flight.
// Depends on mket_pkg and mket_keys.
`default_nettype none

module multi_key_event_tracker #(
    parameter int NUM_KEYS   = 16,
    parameter int TICK_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  mket_pkg::mket_in_t    s_item,
    output logic                  m_valid,
    input  wire                   m_ready,
    output mket_pkg::mket_out_t   m_result,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [2:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mket_pkg::*;

    logic      in_valid_reg, in_valid_next;
    mket_in_t  in_item_reg;
    logic      m_valid_reg, m_valid_next;
    mket_out_t result_reg;
    mket_out_t core_result;
    mket_cfg_t cfg_reg, cfg_next;
    logic      advance, fire, cfg_write;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_result = result_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            result_reg <= core_result;
        end
    end

    mket_keys #(
        .NUM_KEYS   (NUM_KEYS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_keys (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_RELEASE_MASK: cfg_next.release_event_mask = pwdata[15:0];
                REG_DOWN_LEVEL:   cfg_next.down_level         = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RELEASE_MASK: prdata = {16'd0, cfg_reg.release_event_mask};
            REG_DOWN_LEVEL:   prdata = {31'd0, cfg_reg.down_level};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire
